/* rtl/cursor_linked_list_engine_assert.svh */
// Assertion macros used by the cursor linked-list engine sequencer.
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/clle_pkg.sv */
// Shared types and constants of the cursor linked-list engine.
`default_nettype none

package clle_pkg;

  localparam int CELL_W = 6;
  localparam int VAL_W  = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_FIND   = 3'd2,
    MODE_PRED   = 3'd3,
    MODE_DELETE = 3'd4,
    MODE_EMPTY  = 3'd5,
    MODE_WALK   = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFREE   = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [VAL_W-1:0]  value;
    status_e           status;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic              lnk_we;
    logic              val_we;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] lnk_data;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/clle_store.sv */
// Link and value memories of the cell store, one read port and one write port each.
`default_nettype none

module clle_store #(
  parameter int CELL_COUNT  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clle_pkg::mem_req_t           req_i,
  input  logic [VALUE_WIDTH-1:0]       wr_val_i,
  output logic [clle_pkg::CELL_W-1:0] lnk_o,
  output logic [VALUE_WIDTH-1:0]       val_o
);

  localparam int LW = $clog2(CELL_COUNT);
  localparam int XW = clle_pkg::CELL_W + 1;

  logic [LW-1:0]          link_mem [CELL_COUNT];
  logic [VALUE_WIDTH-1:0] val_mem  [CELL_COUNT];
  logic [CELL_COUNT-1:0]  lvld_q;

  logic [LW-1:0]          rd_idx;
  logic [LW-1:0]          wr_idx;
  logic                   rd_in;
  logic                   wr_in;
  logic [LW-1:0]          rd_idx_q;
  logic                   rd_in_q;
  logic                   rd_vld_q;
  logic [LW-1:0]          lnk_mem_q;
  logic [VALUE_WIDTH-1:0] val_mem_q;
  logic [XW-1:0]          rst_sum;
  logic [clle_pkg::CELL_W-1:0] rst_lnk;

  assign rd_idx = req_i.rd_addr[LW-1:0];
  assign wr_idx = req_i.wr_addr[LW-1:0];
  assign rd_in  = ({1'b0, req_i.rd_addr} < XW'(CELL_COUNT));
  assign wr_in  = ({1'b0, req_i.wr_addr} < XW'(CELL_COUNT));

  always_ff @(posedge clk_i) begin
    if (req_i.lnk_we && wr_in) begin
      link_mem[wr_idx] <= req_i.lnk_data[LW-1:0];
    end
    if (req_i.val_we && wr_in) begin
      val_mem[wr_idx] <= wr_val_i;
    end
    if (req_i.rd_en) begin
      lnk_mem_q <= link_mem[rd_idx];
      val_mem_q <= val_mem[rd_idx];
      rd_idx_q  <= rd_idx;
    end
  end

  // An entry never written since reset still holds its reset link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvld_q   <= '0;
      rd_in_q  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.lnk_we && wr_in) begin
        lvld_q[wr_idx] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_in_q  <= rd_in;
        rd_vld_q <= rd_in ? lvld_q[rd_idx] : 1'b0;
      end
    end
  end

  assign rst_sum = XW'(rd_idx_q) + XW'(1);
  assign rst_lnk = (rst_sum < XW'(CELL_COUNT)) ? rst_sum[clle_pkg::CELL_W-1:0] : '0;

  always_comb begin
    if (!rd_in_q) begin
      lnk_o = '0;
    end else if (rd_vld_q) begin
      lnk_o = clle_pkg::CELL_W'(lnk_mem_q);
    end else begin
      lnk_o = rst_lnk;
    end
  end

  assign val_o = rd_in_q ? val_mem_q : '0;

endmodule

`default_nettype wire

/* rtl/clle_seq.sv */
// Command sequencer: walks the store one cell per read and performs the link updates.
`default_nettype none

`include "cursor_linked_list_engine_assert.svh"

module clle_seq #(
  parameter int CELL_COUNT  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [clle_pkg::MODE_W-1:0]  mode_i,
  input  logic [clle_pkg::CELL_W-1:0]  list_head_i,
  input  logic [clle_pkg::VAL_W-1:0]   value_i,
  input  logic [clle_pkg::CELL_W-1:0]  position_i,
  output clle_pkg::mem_req_t           req_o,
  output logic [VALUE_WIDTH-1:0]       wr_val_o,
  input  logic [clle_pkg::CELL_W-1:0]  lnk_i,
  input  logic [VALUE_WIDTH-1:0]       val_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output clle_pkg::res_t               res_o
);

  localparam int CNT_W = $clog2(CELL_COUNT + 1);
  localparam int XW    = clle_pkg::CELL_W + 1;
  localparam int CW    = clle_pkg::CELL_W;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_START   = 5'd1;
  localparam logic [4:0] ST_ALLOC1  = 5'd2;
  localparam logic [4:0] ST_ALLOC2  = 5'd3;
  localparam logic [4:0] ST_ALLOC3  = 5'd4;
  localparam logic [4:0] ST_TAIL0   = 5'd5;
  localparam logic [4:0] ST_TAILW   = 5'd6;
  localparam logic [4:0] ST_EMP_H   = 5'd7;
  localparam logic [4:0] ST_EMP_W1  = 5'd8;
  localparam logic [4:0] ST_EMP_W2  = 5'd9;
  localparam logic [4:0] ST_EMP_W3  = 5'd10;
  localparam logic [4:0] ST_FIND_H  = 5'd11;
  localparam logic [4:0] ST_FINDW   = 5'd12;
  localparam logic [4:0] ST_PRED_H  = 5'd13;
  localparam logic [4:0] ST_PREDW   = 5'd14;
  localparam logic [4:0] ST_DELW    = 5'd15;
  localparam logic [4:0] ST_DEL1    = 5'd16;
  localparam logic [4:0] ST_DEL2    = 5'd17;
  localparam logic [4:0] ST_DEL3    = 5'd18;
  localparam logic [4:0] ST_DEL4    = 5'd19;
  localparam logic [4:0] ST_WALK_H  = 5'd20;
  localparam logic [4:0] ST_WALKW   = 5'd21;
  localparam logic [4:0] ST_EMIT    = 5'd22;

  logic [4:0]                 state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [clle_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [CW-1:0]              head_q, head_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic [CW-1:0]              prev_q, prev_d;
  logic [CW-1:0]              cur_q, cur_d;
  logic [CW-1:0]              alloc_q, alloc_d;
  logic [VALUE_WIDTH-1:0]     x_q, x_d;
  clle_pkg::res_t             res_q, res_d;

  logic [VALUE_WIDTH-1:0]     x_trim;
  logic [clle_pkg::VAL_W-1:0] val_ext;
  logic                       head_oor;
  logic                       cnt_end;
  logic                       walk_fin;

  if (VALUE_WIDTH <= clle_pkg::VAL_W) begin : g_x_narrow
    assign x_trim = value_i[VALUE_WIDTH-1:0];
  end else begin : g_x_wide
    assign x_trim = {{(VALUE_WIDTH - clle_pkg::VAL_W){1'b0}}, value_i};
  end

  if (VALUE_WIDTH >= clle_pkg::VAL_W) begin : g_v_wide
    assign val_ext = val_i[clle_pkg::VAL_W-1:0];
  end else begin : g_v_narrow
    assign val_ext = {{(clle_pkg::VAL_W - VALUE_WIDTH){1'b0}}, val_i};
  end

  assign head_oor = ({1'b0, head_q} >= XW'(CELL_COUNT));
  assign cnt_end  = (cnt_q == CNT_W'(CELL_COUNT));
  assign walk_fin = (lnk_i == '0) || (cnt_q >= CNT_W'(CELL_COUNT - 3));

  function automatic clle_pkg::res_t mk_res(input logic [CW-1:0] idx,
                                            input logic [clle_pkg::VAL_W-1:0] v,
                                            input clle_pkg::status_e s,
                                            input logic l);
    clle_pkg::res_t r;
    r.cell_idx = idx;
    r.value    = v;
    r.status   = s;
    r.last     = l;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    head_d  = head_q;
    pos_d   = pos_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    alloc_d = alloc_q;
    x_d     = x_q;
    res_d   = res_q;
    req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          head_d  = list_head_i;
          x_d     = x_trim;
          pos_d   = position_i;
          state_d = ST_START;
        end
      end
      ST_START: begin
        case (mode_q)
          clle_pkg::MODE_CREATE, clle_pkg::MODE_APPEND: begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = '0;
            state_d       = ST_ALLOC1;
          end
          clle_pkg::MODE_FIND: begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = head_q;
            state_d       = ST_FIND_H;
          end
          clle_pkg::MODE_PRED: begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = head_q;
            prev_d        = head_q;
            state_d       = ST_PRED_H;
          end
          clle_pkg::MODE_DELETE: begin
            if (pos_q == '0) begin
              res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
              state_d = ST_EMIT;
            end else begin
              req_o.rd_en   = 1'b1;
              req_o.rd_addr = head_q;
              prev_d        = head_q;
              cnt_d         = '0;
              state_d       = ST_DELW;
            end
          end
          clle_pkg::MODE_EMPTY: begin
            if ((head_q == '0) || head_oor) begin
              res_d   = mk_res('0, '0, clle_pkg::STAT_OK, 1'b1);
              state_d = ST_EMIT;
            end else begin
              req_o.rd_en   = 1'b1;
              req_o.rd_addr = head_q;
              state_d       = ST_EMP_H;
            end
          end
          clle_pkg::MODE_WALK: begin
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = head_q;
            state_d       = ST_WALK_H;
          end
          default: begin
            res_d   = mk_res('0, '0, clle_pkg::STAT_OK, 1'b1);
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_ALLOC1: begin
        if (lnk_i == '0) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOFREE, 1'b1);
          state_d = ST_EMIT;
        end else begin
          alloc_d       = lnk_i;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
          state_d       = ST_ALLOC2;
        end
      end
      ST_ALLOC2: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = '0;
        req_o.lnk_data = lnk_i;
        state_d        = ST_ALLOC3;
      end
      ST_ALLOC3: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = alloc_q;
        req_o.lnk_data = '0;
        if (mode_q == clle_pkg::MODE_APPEND) begin
          req_o.val_we = 1'b1;
          prev_d       = head_q;
          state_d      = ST_TAIL0;
        end else begin
          res_d   = mk_res(alloc_q, '0, clle_pkg::STAT_OK, 1'b1);
          state_d = ST_EMIT;
        end
      end
      ST_TAIL0: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = prev_q;
        cnt_d         = '0;
        state_d       = ST_TAILW;
      end
      ST_TAILW: begin
        if (!cnt_end && (lnk_i != '0)) begin
          prev_d        = lnk_i;
          cnt_d         = cnt_q + CNT_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
        end else if (mode_q == clle_pkg::MODE_APPEND) begin
          req_o.lnk_we   = 1'b1;
          req_o.wr_addr  = prev_q;
          req_o.lnk_data = alloc_q;
          res_d          = mk_res(alloc_q, '0, clle_pkg::STAT_OK, 1'b1);
          state_d        = ST_EMIT;
        end else begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = '0;
          state_d       = ST_EMP_W1;
        end
      end
      ST_EMP_H: begin
        if (lnk_i == '0) begin
          res_d   = mk_res(head_q, '0, clle_pkg::STAT_OK, 1'b1);
          state_d = ST_EMIT;
        end else begin
          alloc_d       = lnk_i;
          prev_d        = lnk_i;
          cnt_d         = '0;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
          state_d       = ST_TAILW;
        end
      end
      ST_EMP_W1: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = prev_q;
        req_o.lnk_data = lnk_i;
        state_d        = ST_EMP_W2;
      end
      ST_EMP_W2: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = '0;
        req_o.lnk_data = alloc_q;
        state_d        = ST_EMP_W3;
      end
      ST_EMP_W3: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = head_q;
        req_o.lnk_data = '0;
        res_d          = mk_res(head_q, '0, clle_pkg::STAT_OK, 1'b1);
        state_d        = ST_EMIT;
      end
      ST_FIND_H: begin
        if (lnk_i == '0) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          state_d = ST_EMIT;
        end else begin
          cur_d         = lnk_i;
          cnt_d         = '0;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
          state_d       = ST_FINDW;
        end
      end
      ST_FINDW: begin
        if (val_i == x_q) begin
          res_d   = mk_res(cur_q, '0, clle_pkg::STAT_OK, 1'b1);
          state_d = ST_EMIT;
        end else if (cnt_end || (lnk_i == '0)) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          state_d = ST_EMIT;
        end else begin
          cur_d         = lnk_i;
          cnt_d         = cnt_q + CNT_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
        end
      end
      ST_PRED_H: begin
        if (lnk_i == '0) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          state_d = ST_EMIT;
        end else begin
          cur_d         = lnk_i;
          cnt_d         = '0;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
          state_d       = ST_PREDW;
        end
      end
      ST_PREDW: begin
        // The successor of prev_q is cur_q, whose value and link are on the read port.
        if (val_i == x_q) begin
          res_d   = mk_res(prev_q, '0, clle_pkg::STAT_OK, 1'b1);
          state_d = ST_EMIT;
        end else if (cnt_end || (lnk_i == '0)) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          state_d = ST_EMIT;
        end else begin
          prev_d        = cur_q;
          cur_d         = lnk_i;
          cnt_d         = cnt_q + CNT_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
        end
      end
      ST_DELW: begin
        if (lnk_i == pos_q) begin
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = pos_q;
          state_d       = ST_DEL1;
        end else if (cnt_end || (lnk_i == '0)) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          state_d = ST_EMIT;
        end else begin
          prev_d        = lnk_i;
          cnt_d         = cnt_q + CNT_W'(1);
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
        end
      end
      ST_DEL1: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = prev_q;
        req_o.lnk_data = lnk_i;
        state_d        = ST_DEL2;
      end
      ST_DEL2: begin
        req_o.rd_en   = 1'b1;
        req_o.rd_addr = '0;
        state_d       = ST_DEL3;
      end
      ST_DEL3: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = pos_q;
        req_o.lnk_data = lnk_i;
        state_d        = ST_DEL4;
      end
      ST_DEL4: begin
        req_o.lnk_we   = 1'b1;
        req_o.wr_addr  = '0;
        req_o.lnk_data = pos_q;
        res_d          = mk_res(pos_q, '0, clle_pkg::STAT_OK, 1'b1);
        state_d        = ST_EMIT;
      end
      ST_WALK_H: begin
        if (lnk_i == '0) begin
          res_d   = mk_res('0, '0, clle_pkg::STAT_OK, 1'b1);
          state_d = ST_EMIT;
        end else begin
          cur_d         = lnk_i;
          cnt_d         = '0;
          req_o.rd_en   = 1'b1;
          req_o.rd_addr = lnk_i;
          state_d       = ST_WALKW;
        end
      end
      ST_WALKW: begin
        res_d   = mk_res(cur_q, val_ext, clle_pkg::STAT_OK, walk_fin);
        cur_d   = lnk_i;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          if (res_q.last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d         = cnt_q + CNT_W'(1);
            req_o.rd_en   = 1'b1;
            req_o.rd_addr = cur_q;
            state_d       = ST_WALKW;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    head_q  <= head_d;
    pos_q   <= pos_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    alloc_q <= alloc_d;
    x_q     <= x_d;
    res_q   <= res_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;
  assign wr_val_o    = x_q;

  `CLLE_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, req_o.rd_en && req_o.lnk_we, req_o.rd_addr != req_o.wr_addr, "link read and write hit the same cell in one cycle")
  `CLLE_ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, state_q == ST_IDLE, !req_o.lnk_we && !req_o.val_we && !res_valid_o, "store written or result offered while idle")
  `CLLE_ASSERT_IMPL(a_nofree_src, clk_i, rst_ni, res_valid_o && (res_q.status == clle_pkg::STAT_NOFREE), (mode_q == clle_pkg::MODE_CREATE) || (mode_q == clle_pkg::MODE_APPEND), "out of free cells reported by a command that allocates nothing")
  `CLLE_ASSERT_IMPL(a_fail_shape, clk_i, rst_ni, res_valid_o && (res_q.status != clle_pkg::STAT_OK), (res_q.cell_idx == '0) && res_q.last, "failed command must return cell zero as its last result")
  `CLLE_ASSERT_NEXT(a_walk_step, clk_i, rst_ni, res_valid_o && res_ready_i && !res_q.last, state_q == ST_WALKW, "non-final result not followed by the next walk step")

endmodule

`default_nettype wire

/* rtl/cursor_linked_list_engine.sv */
// Searches, append, delete and empty visit the cells of a chain one after another, since
// each step waits on one link read.
// One command is in work at a time; a walk reads each next node only once the previous one is taken.
// Reset: asynchronous, active low; the free chain 0->1->...->CELL_COUNT-1 holds at once
// through per-cell valid flops on the link memory, so no clearing pass runs; values are
// undefined until written.
`default_nettype none

module cursor_linked_list_engine #(
  parameter int CELL_COUNT  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [clle_pkg::MODE_W-1:0]  mode_i,
  input  logic [clle_pkg::CELL_W-1:0]  list_head_i,
  input  logic [clle_pkg::VAL_W-1:0]   value_i,
  input  logic [clle_pkg::CELL_W-1:0]  position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [clle_pkg::CELL_W-1:0]  cell_res_o,
  output logic [clle_pkg::VAL_W-1:0]   cell_value_o,
  output logic [clle_pkg::STAT_W-1:0]  status_o,
  output logic                         last_o
);

  // The sequencer owns every memory access. It issues at most one read per cycle and
  // never reads a cell in the same cycle that it rewrites that cell's link, so the
  // registered read port of the store needs no forwarding path.
  clle_pkg::mem_req_t     mem_req;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [clle_pkg::CELL_W-1:0] rd_lnk;
  logic [VALUE_WIDTH-1:0] rd_val;

  logic           res_valid;
  logic           res_ready;
  clle_pkg::res_t res;

  // Output register. It decouples the result side from the sequencer, so the next
  // command can be transferred in while the previous result still waits downstream.
  logic           out_valid_q, out_valid_d;
  clle_pkg::res_t out_res_q;

  clle_seq #(
    .CELL_COUNT  (CELL_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .list_head_i (list_head_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .req_o       (mem_req),
    .wr_val_o    (wr_val),
    .lnk_i       (rd_lnk),
    .val_i       (rd_val),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  clle_store #(
    .CELL_COUNT  (CELL_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wr_val_i (wr_val),
    .lnk_o    (rd_lnk),
    .val_o    (rd_val)
  );

  // The register takes a new result whenever it is empty or is being emptied this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_res_o   = out_res_q.cell_idx;
  assign cell_value_o = out_res_q.value;
  assign status_o     = out_res_q.status;
  assign last_o       = out_res_q.last;

endmodule

`default_nettype wire

/* tb/tb_cursor_linked_list_engine.sv */
// Self-checking testbench of the cursor linked-list engine with its own free-list model.
`timescale 1ns / 100ps

module tb_cursor_linked_list_engine;

  localparam int CELLS        = 64;
  localparam int WALK_CAP     = CELLS - 2;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_GAP      = 6;
  localparam int MAX_HEADS    = 6;
  localparam int CMD_TARGET   = 360;
  localparam int MAX_REPORTS  = 10;
  // The slowest legal command is a 62-node walk with every transfer stalled.
  localparam int CYCLE_LIMIT  = 1_200_000;
  // A search or splice follows at most one chain of the store.
  localparam int DRAIN_CYCLES = 400;

  // Mode 7 is not an operation of the block; it answers with a single OK result of cell 0, value 0, marked last.
  localparam logic [clle_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [clle_pkg::MODE_W-1:0] mode;
    logic [clle_pkg::CELL_W-1:0] head;
    logic [clle_pkg::VAL_W-1:0]  data;
    logic [clle_pkg::CELL_W-1:0] pos;
  } list_cmd_t;

  typedef struct packed {
    logic [clle_pkg::CELL_W-1:0] idx;
    logic [clle_pkg::VAL_W-1:0]  data;
    clle_pkg::status_e           status;
    logic                        tail_mark;
  } node_result_t;

  // Ports of the block. Every input holds a known value from time zero.
  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic [clle_pkg::MODE_W-1:0] mode_i       = '0;
  logic [clle_pkg::CELL_W-1:0] list_head_i  = '0;
  logic [clle_pkg::VAL_W-1:0]  value_i      = '0;
  logic [clle_pkg::CELL_W-1:0] position_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic [clle_pkg::CELL_W-1:0] cell_res_o;
  logic [clle_pkg::VAL_W-1:0]  cell_value_o;
  logic [clle_pkg::STAT_W-1:0] status_o;
  logic                        last_o;

  // Shadow copy of the cell store. It advances when a command transfer is accepted.
  logic [clle_pkg::CELL_W-1:0] link_mem [CELLS];
  logic [clle_pkg::VAL_W-1:0]  val_mem  [CELLS];

  list_cmd_t                   command_q[$];
  node_result_t                answers_due[$];
  logic [clle_pkg::CELL_W-1:0] heads[$];

  int  commands_sent    = 0;
  int  commands_taken   = 0;
  int  commands_counted = 0;
  int  failures         = 0;
  int  cycle_count      = 0;

  // Driver and receiver state. When calm is set, neither side idles.
  bit        calm       = 1'b0;
  bit        holding    = 1'b0;
  bit        presenting = 1'b0;
  int        gap_left   = 0;
  int        stall_left = 0;
  list_cmd_t held_cmd   = '0;

  cursor_linked_list_engine DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .list_head_i  (list_head_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_res_o   (cell_res_o),
    .cell_value_o (cell_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic logic [clle_pkg::CELL_W-1:0] rand_cell();
    return clle_pkg::CELL_W'($urandom_range(0, CELLS - 1));
  endfunction

  // Number of cells that follow start along its chain, bounded like the block's loops.
  function automatic int chain_length(input logic [clle_pkg::CELL_W-1:0] start);
    logic [clle_pkg::CELL_W-1:0] p;
    int n;
    p = start;
    n = 0;
    while (n < CELLS && link_mem[p] != 0) begin
      p = link_mem[p];
      n++;
    end
    return n;
  endfunction

  // The cell at position idx (counting from zero) after start.
  function automatic logic [clle_pkg::CELL_W-1:0] chain_node(
      input logic [clle_pkg::CELL_W-1:0] start, input int idx);
    logic [clle_pkg::CELL_W-1:0] p;
    p = start;
    repeat (idx + 1) p = link_mem[p];
    return p;
  endfunction

  // Last cell of the chain that starts at start; a looping chain stops after CELLS steps.
  function automatic logic [clle_pkg::CELL_W-1:0] chain_tail(
      input logic [clle_pkg::CELL_W-1:0] start);
    logic [clle_pkg::CELL_W-1:0] p;
    int n;
    p = start;
    for (n = 0; n < CELLS && link_mem[p] != 0; n++) p = link_mem[p];
    return p;
  endfunction

  // Pops the front of the free chain, which cell 0 heads. Zero means nothing is free.
  function automatic logic [clle_pkg::CELL_W-1:0] take_free_cell();
    logic [clle_pkg::CELL_W-1:0] got;
    got = link_mem[0];
    if (got != 0) link_mem[0] = link_mem[got];
    return got;
  endfunction

  task automatic queue_answer(input logic [clle_pkg::CELL_W-1:0] idx,
                              input logic [clle_pkg::VAL_W-1:0] data,
                              input clle_pkg::status_e status, input logic tail_mark);
    node_result_t r;
    r.idx       = idx;
    r.data      = data;
    r.status    = status;
    r.tail_mark = tail_mark;
    answers_due.push_back(r);
  endtask

  // Applies one accepted command to the shadow store and queues the results it owes.
  task automatic predict_list_command(input list_cmd_t cmd);
    logic [clle_pkg::CELL_W-1:0] p, nx, got;
    int n, k;
    case (cmd.mode)
      clle_pkg::MODE_CREATE: begin
        got = take_free_cell();
        if (got == 0) begin
          queue_answer('0, '0, clle_pkg::STAT_NOFREE, 1'b1);
        end else begin
          link_mem[got] = '0;
          queue_answer(got, '0, clle_pkg::STAT_OK, 1'b1);
        end
      end
      clle_pkg::MODE_APPEND: begin
        // The new cell leaves the free chain before the tail is searched.
        got = take_free_cell();
        if (got == 0) begin
          queue_answer('0, '0, clle_pkg::STAT_NOFREE, 1'b1);
        end else begin
          val_mem[got]  = cmd.data;
          link_mem[got] = '0;
          link_mem[chain_tail(cmd.head)] = got;
          queue_answer(got, '0, clle_pkg::STAT_OK, 1'b1);
        end
      end
      clle_pkg::MODE_FIND: begin
        p = link_mem[cmd.head];
        for (n = 0; n < CELLS && p != 0 && val_mem[p] != cmd.data; n++) p = link_mem[p];
        if (p != 0 && val_mem[p] != cmd.data) p = '0;
        if (p != 0) queue_answer(p, '0, clle_pkg::STAT_OK, 1'b1);
        else queue_answer('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
      end
      clle_pkg::MODE_PRED: begin
        // The search ends at the tail rather than wrapping through cell 0.
        p = cmd.head;
        for (n = 0; n < CELLS && link_mem[p] != 0 && val_mem[link_mem[p]] != cmd.data; n++)
          p = link_mem[p];
        if (link_mem[p] == 0 || val_mem[link_mem[p]] != cmd.data)
          queue_answer('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
        else
          queue_answer(p, '0, clle_pkg::STAT_OK, 1'b1);
      end
      clle_pkg::MODE_DELETE: begin
        // Cell 0 heads the free chain and can never be removed.
        if (cmd.pos == 0) begin
          queue_answer('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
        end else begin
          p = cmd.head;
          for (n = 0; n < CELLS && link_mem[p] != 0 && link_mem[p] != cmd.pos; n++)
            p = link_mem[p];
          if (link_mem[p] != cmd.pos) begin
            queue_answer('0, '0, clle_pkg::STAT_NOTFOUND, 1'b1);
          end else begin
            link_mem[p]       = link_mem[cmd.pos];
            link_mem[cmd.pos] = link_mem[0];
            link_mem[0]       = cmd.pos;
            queue_answer(cmd.pos, '0, clle_pkg::STAT_OK, 1'b1);
          end
        end
      end
      clle_pkg::MODE_EMPTY: begin
        // A head of 0 would be the free chain itself, so the block ignores it.
        if (cmd.head == 0) begin
          queue_answer('0, '0, clle_pkg::STAT_OK, 1'b1);
        end else begin
          got = link_mem[cmd.head];
          if (got != 0) begin
            p = chain_tail(got);
            link_mem[p]        = link_mem[0];
            link_mem[0]        = got;
            link_mem[cmd.head] = '0;
          end
          queue_answer(cmd.head, '0, clle_pkg::STAT_OK, 1'b1);
        end
      end
      clle_pkg::MODE_WALK: begin
        p = link_mem[cmd.head];
        if (p == 0) begin
          queue_answer('0, '0, clle_pkg::STAT_OK, 1'b1);
        end else begin
          k = 0;
          while (p != 0 && k < WALK_CAP) begin
            nx = link_mem[p];
            queue_answer(p, val_mem[p], clle_pkg::STAT_OK, (nx == 0) || (k + 1 >= WALK_CAP));
            k++;
            p = nx;
          end
        end
      end
      default: queue_answer('0, '0, clle_pkg::STAT_OK, 1'b1);
    endcase
  endtask

  task automatic log_failure(input string what, input node_result_t want);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t %s: exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b (cell/value/status/last)",
               $time, what, want.idx, want.data, want.status, want.tail_mark,
               cell_res_o, cell_value_o, status_o, last_o);
  endtask

  // Hands one command to the driver and returns once its transfer has been accepted, so
  // the shadow store already reflects it when the next command is chosen.
  task automatic send(input logic [clle_pkg::MODE_W-1:0] mode,
                      input logic [clle_pkg::CELL_W-1:0] head,
                      input logic [clle_pkg::VAL_W-1:0] data,
                      input logic [clle_pkg::CELL_W-1:0] pos);
    command_q.push_back('{mode, head, data, pos});
    commands_sent++;
    if (mode != MODE_UNUSED && !(mode == clle_pkg::MODE_EMPTY && head == 0))
      commands_counted++;
    do @(negedge clk_i); while (commands_taken != commands_sent);
  endtask

  task automatic wait_drained();
    while (commands_taken != commands_sent || answers_due.size() != 0) @(negedge clk_i);
  endtask

  // Command driver. Each command waits a random number of cycles before valid rises;
  // valid then stays high with a steady payload until the transfer completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_list_command(held_cmd);
        commands_taken++;
        holding    = 1'b0;
        presenting = 1'b0;
      end
      if (!holding && command_q.size() != 0) begin
        held_cmd = command_q.pop_front();
        holding  = 1'b1;
        gap_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (holding && !presenting) begin
        if (gap_left == 0) presenting = 1'b1;
        else gap_left--;
      end
      in_valid_i  <= presenting;
      mode_i      <= held_cmd.mode;
      list_head_i <= held_cmd.head;
      value_i     <= held_cmd.data;
      position_i  <= held_cmd.pos;
    end
  end

  // Result monitor. Every transfer is checked against the oldest owed result, then the
  // receiver draws how many cycles it holds ready low before taking the next one.
  always @(posedge clk_i) begin : result_monitor
    node_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          log_failure("result with nothing owed", '0);
        end else begin
          want = answers_due.pop_front();
          if (cell_res_o !== want.idx || cell_value_o !== want.data ||
              status_o !== want.status || last_o !== want.tail_mark)
            log_failure("mismatch", want);
        end
        stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [clle_pkg::CELL_W-1:0] h, node;
    logic [clle_pkg::VAL_W-1:0]  v;
    int len, free_cells, pick, burst;

    // Reset image of the store: cell i links i+1, the last cell ends the free chain.
    for (int i = 0; i < CELLS; i++) begin
      link_mem[i] = (i + 1 < CELLS) ? clle_pkg::CELL_W'(i + 1) : '0;
      val_mem[i]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on a single list, so that later a walk can cover every spare cell.
    h = link_mem[0];
    send(clle_pkg::MODE_CREATE, rand_cell(), $urandom, rand_cell());
    heads.push_back(h);
    send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());          // empty list
    send(clle_pkg::MODE_FIND, h, 32'h0000_0000, rand_cell());     // nothing to find yet
    send(clle_pkg::MODE_PRED, h, 32'h0000_0000, rand_cell());
    send(clle_pkg::MODE_APPEND, h, 32'h0000_0000, rand_cell());
    send(clle_pkg::MODE_APPEND, h, 32'hFFFF_FFFF, rand_cell());
    send(clle_pkg::MODE_APPEND, h, 32'h8000_0001, rand_cell());
    send(clle_pkg::MODE_APPEND, h, 32'hFFFF_FFFF, rand_cell());   // duplicate value
    send(clle_pkg::MODE_APPEND, h, 32'h5555_AAAA, rand_cell());
    send(clle_pkg::MODE_FIND, h, 32'hFFFF_FFFF, rand_cell());     // first of the duplicates
    send(clle_pkg::MODE_FIND, h, 32'h0000_0000, rand_cell());
    send(clle_pkg::MODE_PRED, h, 32'hFFFF_FFFF, rand_cell());
    send(clle_pkg::MODE_PRED, h, 32'h0000_0000, rand_cell());     // predecessor is the head
    send(clle_pkg::MODE_FIND, h, 32'h1234_5678, rand_cell());     // absent value
    send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
    send(clle_pkg::MODE_DELETE, h, $urandom, '0);                 // cell zero is never deleted
    node = chain_node(h, 2);
    send(clle_pkg::MODE_DELETE, h, $urandom, node);               // middle node
    send(clle_pkg::MODE_DELETE, h, $urandom, node);               // already gone
    send(clle_pkg::MODE_DELETE, h, $urandom, chain_node(h, chain_length(h) - 1));  // tail
    send(clle_pkg::MODE_EMPTY, '0, $urandom, rand_cell());        // head zero is ignored
    send(MODE_UNUSED, rand_cell(), $urandom, rand_cell());
    send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
    send(clle_pkg::MODE_EMPTY, h, $urandom, rand_cell());
    send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
    wait_drained();

    // Use up every free cell, then run into exhaustion and walk the longest list.
    while (link_mem[0] != 0) send(clle_pkg::MODE_APPEND, h, $urandom, rand_cell());
    send(clle_pkg::MODE_APPEND, h, $urandom, rand_cell());
    send(clle_pkg::MODE_CREATE, rand_cell(), $urandom, rand_cell());
    send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
    node = chain_node(h, chain_length(h) - 1);
    send(clle_pkg::MODE_FIND, h, val_mem[node], rand_cell());
    send(clle_pkg::MODE_PRED, h, val_mem[node], rand_cell());
    send(clle_pkg::MODE_DELETE, h, $urandom, node);
    send(clle_pkg::MODE_EMPTY, h, $urandom, rand_cell());
    wait_drained();

    // Random part: mostly well-formed work on known lists, plus some stray commands.
    // Find, predecessor and walk only ever start at created heads, whose nodes all hold
    // appended values.
    while (commands_counted < CMD_TARGET) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      h          = heads[$urandom_range(0, heads.size() - 1)];
      len        = chain_length(h);
      free_cells = chain_length('0);
      pick       = $urandom_range(0, 99);
      if (free_cells == 0 && pick < 50) pick = 90;
      if (pick < 8) begin
        if (heads.size() < MAX_HEADS || free_cells == 0) begin
          node = link_mem[0];
          send(clle_pkg::MODE_CREATE, rand_cell(), $urandom, rand_cell());
          if (node != 0) heads.push_back(node);
        end else begin
          send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
        end
      end else if (pick < 38) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          v   = $urandom;
          len = chain_length(h);
          if (len != 0 && $urandom_range(0, 3) == 0)
            v = val_mem[chain_node(h, $urandom_range(0, len - 1))];
          send(clle_pkg::MODE_APPEND, h, v, rand_cell());
        end
      end else if (pick < 67) begin
        v = $urandom;
        if (len != 0 && $urandom_range(0, 9) < 7)
          v = val_mem[chain_node(h, $urandom_range(0, len - 1))];
        if (pick < 55) send(clle_pkg::MODE_FIND, h, v, rand_cell());
        else send(clle_pkg::MODE_PRED, h, v, rand_cell());
      end else if (pick < 79) begin
        if (len != 0 && $urandom_range(0, 3) != 0)
          send(clle_pkg::MODE_DELETE, h, $urandom,
               chain_node(h, $urandom_range(0, len - 1)));
        else
          send(clle_pkg::MODE_DELETE, rand_cell(), $urandom, rand_cell());
      end else if (pick < 87) begin
        send(clle_pkg::MODE_WALK, h, $urandom, rand_cell());
      end else if (pick < 93) begin
        if ($urandom_range(0, 3) == 0)
          send(clle_pkg::MODE_EMPTY, rand_cell(), $urandom, rand_cell());
        else
          send(clle_pkg::MODE_EMPTY, h, $urandom, rand_cell());
      end else if (pick < 96) begin
        send(clle_pkg::MODE_APPEND, rand_cell(), $urandom, rand_cell());
      end else if (pick < 98) begin
        send(MODE_UNUSED, rand_cell(), $urandom, rand_cell());
      end else begin
        // Hold the next command back until every owed result has come out.
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
